[rtl/polygon_inside_polygon_test_unit_macros.svh]
// Assertion macros for the polygon inside polygon test unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef POLYGON_INSIDE_POLYGON_TEST_UNIT_MACROS_SVH
`define POLYGON_INSIDE_POLYGON_TEST_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PIPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the same edge.
`define PIPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one on the next edge.
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pipt_pkg.sv]
// Shared constants, codes and structs of the polygon inside polygon test unit.
// No dependencies; used by the interfaces and every RTL module but pipt_ram.
package pipt_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CountW      = $clog2(MaxVertices + 1);
  localparam int unsigned CoordW      = 32;
  localparam int unsigned VtxW        = 2 * CoordW;
  localparam int unsigned TallyW      = 32;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxVertices);

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_LAST   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic                     vld;
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
  } edge_t;

  typedef struct packed {
    logic busy;
    logic parity;
  } edge_stat_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [VtxW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

[rtl/pipt_if.sv]
// Handshake channels of the polygon inside polygon test unit: test/vertex input
// and result output. Depends on pipt_pkg.
interface pipt_in_if import pipt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;

  modport source (output valid, output cmd, output point_x, output point_y, input ready);
  modport sink   (input valid, input cmd, input point_x, input point_y, output ready);
endinterface

interface pipt_out_if import pipt_pkg::*; ();
  logic valid;
  logic ready;
  logic point_inside;
  logic polygon_inside;
  logic last;

  modport source (output valid, output point_inside, output polygon_inside, output last,
                  input ready);
  modport sink   (input valid, input point_inside, input polygon_inside, input last,
                  output ready);
endinterface

[rtl/pipt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pipt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pipt_edge.sv]
// Edge crossing pipeline: one edge per cycle, skip rules, exact cross-multiplied
// compare, and a running crossing parity. Depends on pipt_pkg.
module pipt_edge import pipt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  edge_t                    edge_i,
  output edge_stat_t               stat_o
);

  // stage A: differences
  logic                   vld_a_q;
  logic signed [CoordW:0] ea_q, eb_q, ey0_q, ey1_q;
  logic                   horiz_q;

  // stage B: magnitudes and decision flags
  logic              vld_b_q, cnt_b_q, right_b_q, left_b_q, a_pos_b_q;
  logic [CoordW-1:0] ma_q, mb_q, d0_q, d1_q;
  logic              cnt_b_d;
  logic              gt0, gt1, lt0, lt1, z0, z1;

  // stage C: products
  logic              vld_c_q, cnt_c_q, right_c_q, left_c_q, a_pos_c_q;
  logic [VtxW-1:0]   p0_q, p1_q;
  logic [VtxW-1:0]   p0_d, p1_d;

  logic parity_q;
  logic hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      vld_c_q  <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      vld_a_q <= edge_i.vld;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      if (clr_i) begin
        parity_q <= 1'b0;
      end else if (vld_c_q && hit) begin
        parity_q <= ~parity_q;
      end
    end
  end

  assign gt0 = !ey0_q[CoordW] && (ey0_q != '0);
  assign gt1 = !ey1_q[CoordW] && (ey1_q != '0);
  assign lt0 = ey0_q[CoordW];
  assign lt1 = ey1_q[CoordW];
  assign z0  = (ey0_q == '0);
  assign z1  = (ey1_q == '0);
  assign cnt_b_d = !((gt0 && gt1) || (lt0 && lt1) || horiz_q || (z0 && !gt1) || (z1 && !gt0));

  assign p0_d = ma_q * d1_q;
  assign p1_d = mb_q * d0_q;

  always_ff @(posedge clk_i) begin
    ea_q      <= (CoordW+1)'(edge_i.x0) - (CoordW+1)'(px_i);
    eb_q      <= (CoordW+1)'(edge_i.x1) - (CoordW+1)'(px_i);
    ey0_q     <= (CoordW+1)'(edge_i.y0) - (CoordW+1)'(py_i);
    ey1_q     <= (CoordW+1)'(edge_i.y1) - (CoordW+1)'(py_i);
    horiz_q   <= (edge_i.y0 == edge_i.y1);

    cnt_b_q   <= cnt_b_d;
    right_b_q <= !ea_q[CoordW] && !eb_q[CoordW];
    left_b_q  <= ea_q[CoordW] && eb_q[CoordW];
    a_pos_b_q <= !ea_q[CoordW];
    ma_q      <= ea_q[CoordW]  ? CoordW'(-ea_q)  : ea_q[CoordW-1:0];
    mb_q      <= eb_q[CoordW]  ? CoordW'(-eb_q)  : eb_q[CoordW-1:0];
    d0_q      <= ey0_q[CoordW] ? CoordW'(-ey0_q) : ey0_q[CoordW-1:0];
    d1_q      <= ey1_q[CoordW] ? CoordW'(-ey1_q) : ey1_q[CoordW-1:0];

    cnt_c_q   <= cnt_b_q;
    right_c_q <= right_b_q;
    left_c_q  <= left_b_q;
    a_pos_c_q <= a_pos_b_q;
    p0_q      <= p0_d;
    p1_q      <= p1_d;
  end

  assign hit = cnt_c_q && (right_c_q ||
               (!left_c_q && (a_pos_c_q ? (p0_q >= p1_q) : (p1_q >= p0_q))));

  assign stat_o.busy   = vld_a_q || vld_b_q || vld_c_q;
  assign stat_o.parity = parity_q;

endmodule

[rtl/pipt_ctrl.sv]
// Command sequencer: vertex store writes, edge walk over the vertex memory,
// inside/tested tallies and the result register. Depends on pipt_pkg.
module pipt_ctrl import pipt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  pipt_in_if.sink                  pt_i,
  pipt_out_if.source               res_o,
  output ram_req_t                 ram_o,
  input  logic [VtxW-1:0]          ram_rdata_i,
  output edge_t                    edge_o,
  output logic signed [CoordW-1:0] px_o,
  output logic signed [CoordW-1:0] py_o,
  output logic                     clr_o,
  input  edge_stat_t               stat_i
);

  `include "polygon_inside_polygon_test_unit_macros.svh"

  state_e              state_q, state_d;
  logic [CountW-1:0]   ref_cnt_q, ref_cnt_d;
  logic [TallyW-1:0]   ins_cnt_q, ins_cnt_d, tst_cnt_q, tst_cnt_d;
  logic [CountW-1:0]   rd_cnt_q, rd_cnt_d;
  logic                rd_vld_q, rd_first_q, rd_last_q, close_q;
  logic                rd_first_d, rd_last_d;
  logic                out_vld_q, out_vld_d;
  logic                out_pi_q, out_poly_q, out_last_q;
  logic                load_out;
  logic                last_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic [VtxW-1:0]     first_vtx_q, prev_vtx_q;
  logic [TallyW-1:0]   ins_nx, tst_nx;
  logic                poly_nx;
  logic                in_acc;
  cmd_e                cmd;

  assign cmd        = cmd_e'(pt_i.cmd);
  assign pt_i.ready = (state_q == ST_IDLE);
  assign in_acc     = pt_i.valid && pt_i.ready;

  assign tst_nx  = (&tst_cnt_q) ? tst_cnt_q : tst_cnt_q + TallyW'(1);
  assign ins_nx  = (stat_i.parity && !(&ins_cnt_q)) ? ins_cnt_q + TallyW'(1) : ins_cnt_q;
  assign poly_nx = last_q && ({ins_nx, 1'b0} >= {1'b0, tst_nx});

  always_comb begin
    state_d    = state_q;
    ref_cnt_d  = ref_cnt_q;
    ins_cnt_d  = ins_cnt_q;
    tst_cnt_d  = tst_cnt_q;
    rd_cnt_d   = rd_cnt_q;
    rd_first_d = 1'b0;
    rd_last_d  = 1'b0;
    out_vld_d  = out_vld_q && !res_o.ready;
    load_out   = 1'b0;
    clr_o      = 1'b0;
    ram_o      = '0;
    ram_o.wdata = {pt_i.point_y, pt_i.point_x};
    ram_o.waddr = ref_cnt_q[AddrW-1:0];
    ram_o.raddr = rd_cnt_q[AddrW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_START: begin
              ram_o.we    = 1'b1;
              ram_o.waddr = '0;
              ref_cnt_d   = CountW'(1);
              ins_cnt_d   = '0;
              tst_cnt_d   = '0;
            end
            CMD_APPEND: begin
              if (ref_cnt_q < MaxCount) begin
                ram_o.we  = 1'b1;
                ref_cnt_d = ref_cnt_q + CountW'(1);
              end
            end
            default: begin
              clr_o    = 1'b1;
              rd_cnt_d = '0;
              state_d  = (ref_cnt_q == '0) ? ST_DONE : ST_WALK;
            end
          endcase
        end
      end
      ST_WALK: begin
        ram_o.re   = 1'b1;
        rd_cnt_d   = rd_cnt_q + CountW'(1);
        rd_first_d = (rd_cnt_q == '0);
        rd_last_d  = (rd_cnt_q + CountW'(1) == ref_cnt_q);
        if (rd_last_d) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !close_q && !stat_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          load_out  = 1'b1;
          out_vld_d = 1'b1;
          ins_cnt_d = last_q ? '0 : ins_nx;
          tst_cnt_d = last_q ? '0 : tst_nx;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ref_cnt_q  <= '0;
      ins_cnt_q  <= '0;
      tst_cnt_q  <= '0;
      rd_cnt_q   <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      rd_last_q  <= 1'b0;
      close_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ref_cnt_q  <= ref_cnt_d;
      ins_cnt_q  <= ins_cnt_d;
      tst_cnt_q  <= tst_cnt_d;
      rd_cnt_q   <= rd_cnt_d;
      rd_vld_q   <= ram_o.re;
      rd_first_q <= rd_first_d;
      rd_last_q  <= rd_last_d;
      close_q    <= rd_vld_q && rd_last_q;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q   <= pt_i.point_x;
      py_q   <= pt_i.point_y;
      last_q <= (cmd == CMD_LAST);
    end
    if (rd_vld_q) begin
      prev_vtx_q <= ram_rdata_i;
      if (rd_first_q) begin
        first_vtx_q <= ram_rdata_i;
      end
    end
    if (load_out) begin
      out_pi_q   <= stat_i.parity;
      out_poly_q <= poly_nx;
      out_last_q <= last_q;
    end
  end

  // edge from the held vertex to the arriving one, or the closing edge
  assign edge_o.vld = (rd_vld_q && !rd_first_q) || close_q;
  assign edge_o.x0  = prev_vtx_q[CoordW-1:0];
  assign edge_o.y0  = prev_vtx_q[VtxW-1:CoordW];
  assign edge_o.x1  = close_q ? first_vtx_q[CoordW-1:0]    : ram_rdata_i[CoordW-1:0];
  assign edge_o.y1  = close_q ? first_vtx_q[VtxW-1:CoordW] : ram_rdata_i[VtxW-1:CoordW];
  assign px_o = px_q;
  assign py_o = py_q;

  assign res_o.valid          = out_vld_q;
  assign res_o.point_inside   = out_pi_q;
  assign res_o.polygon_inside = out_poly_q;
  assign res_o.last           = out_last_q;

  `PIPT_ASSERT(a_ref_cnt_range, ref_cnt_q <= MaxCount, "vertex count beyond store depth")
  `PIPT_ASSERT_IMPL(a_read_in_range, ram_o.re, rd_cnt_q < ref_cnt_q,
                    "vertex read beyond stored count")
  `PIPT_ASSERT_IMPL(a_done_drained, state_q == ST_DONE,
                    !stat_i.busy && !rd_vld_q && !close_q, "result taken before edges drained")
  `PIPT_ASSERT_NEXT(a_close_after_last, rd_vld_q && rd_last_q, edge_o.vld && close_q,
                    "closing edge missing after last vertex")
  `PIPT_ASSERT_IMPL(a_no_write_in_walk, state_q != ST_IDLE, !ram_o.we,
                    "vertex write outside idle")

endmodule

[rtl/polygon_inside_polygon_test_unit.sv]
// Top level of the polygon inside polygon test unit: vertex memory, edge
// pipeline and sequencer. Depends on pipt_pkg, pipt_if, pipt_ram, pipt_edge, pipt_ctrl.
//
// Usage:
//   pt_i carries one command per beat: cmd 0 starts a reference polygon with
//   (point_x, point_y) as its first vertex, cmd 1 appends a vertex (dropped
//   once 1024 vertices are stored), cmd 2 tests a point, cmd 3 tests the last
//   point of a candidate polygon. Only test beats produce a result on res_o:
//   point_inside, and on cmd 3 also polygon_inside (at least half of the
//   candidate's points inside) with last set.
//   Vertex beats leave the unit ready for the next command. For a test beat
//   the single read port of the vertex memory walks the stored vertices one
//   vertex per cycle, followed by the closing edge and the three-stage
//   crossing pipeline; pt_i.ready is low meanwhile. With no vertex stored
//   the walk is skipped.
//   A finished result sits in an output register; the next command is taken
//   while it waits. If res_o stalls, the following test holds in its final
//   state until the pending beat is taken.
//   Reset empties the reference polygon and clears the tallies; the vertex
//   memory itself is not cleared and needs no clearing pass.
module polygon_inside_polygon_test_unit import pipt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pipt_in_if.sink    pt_i,
  pipt_out_if.source res_o
);

  ram_req_t                 ram_req;
  logic [VtxW-1:0]          ram_rdata;
  edge_t                    edge_in;
  edge_stat_t               edge_stat;
  logic signed [CoordW-1:0] px, py;
  logic                     edge_clr;

  pipt_ram #(
    .WIDTH (VtxW),
    .DEPTH (MaxVertices)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  pipt_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (edge_clr),
    .px_i   (px),
    .py_i   (py),
    .edge_i (edge_in),
    .stat_o (edge_stat)
  );

  pipt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_i        (pt_i),
    .res_o       (res_o),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata),
    .edge_o      (edge_in),
    .px_o        (px),
    .py_o        (py),
    .clr_o       (edge_clr),
    .stat_i      (edge_stat)
  );

endmodule

[verif/tb_polygon_inside_polygon_test_unit.sv]
// Self-checking testbench for polygon_inside_polygon_test_unit: checks even-odd verdicts
// and candidate majority votes against an in-bench crossing-count predictor.
// Depends on pipt_pkg, pipt_if and the unit's RTL.
module tb_polygon_inside_polygon_test_unit import pipt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBeats = 510;
  localparam int QuietLimit  = 6000;
  localparam int ReportMax   = 10;
  localparam int IdlePct     = 32;
  localparam int HoldCycles  = 250;
  localparam int HoldAfter   = 60;
  localparam int LongPoly    = 40;

  localparam int ScaleNear = 0;
  localparam int ScaleMid  = 1;
  localparam int ScaleFull = 2;

  localparam logic signed [CoordW-1:0] CMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CMax = 32'sh7FFF_FFFF;

  typedef struct {
    cmd_e                     cmd;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } cmd_beat_t;

  typedef struct packed {
    logic pt_in;
    logic poly_in;
    logic last;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  pipt_in_if  pt_if ();
  pipt_out_if res_if ();

  polygon_inside_polygon_test_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .res_o  (res_if)
  );

  cmd_beat_t pending_q[$];
  verdict_t  verdict_q[$];

  // predictor state
  logic signed [CoordW-1:0] poly_x[MaxVertices];
  logic signed [CoordW-1:0] poly_y[MaxVertices];
  int unsigned              poly_n;
  logic [TallyW-1:0]        hit_tally;
  logic [TallyW-1:0]        test_tally;

  int       n_cmd_beats, n_vertex_beats, n_test_beats, n_verdicts, largest_poly;
  int       n_errors;
  int       quiet_cycles = 0;
  logic     in_beat      = 1'b0;
  logic     hold_done    = 1'b0;
  int       hold_left    = 0;
  verdict_t want, got;

  function automatic bit crosses_right(longint x0, longint y0, longint x1, longint y1,
                                       longint px, longint py);
    longint     a, b, dy0, dy1;
    bit [32:0]  ma, mb, d0, d1;
    bit [65:0]  lhs, rhs;
    a   = x0 - px;
    b   = x1 - px;
    dy0 = y0 - py;
    dy1 = y1 - py;
    if (a >= 0 && b >= 0) return 1'b1;
    if (a < 0 && b < 0) return 1'b0;
    ma  = 33'((a < 0) ? -a : a);
    mb  = 33'((b < 0) ? -b : b);
    d0  = 33'((dy0 < 0) ? -dy0 : dy0);
    d1  = 33'((dy1 < 0) ? -dy1 : dy1);
    lhs = ma * d1;
    rhs = mb * d0;
    return (a >= 0) ? (lhs >= rhs) : (rhs >= lhs);
  endfunction

  function automatic bit point_in_poly(logic signed [CoordW-1:0] px,
                                       logic signed [CoordW-1:0] py);
    bit          parity;
    int unsigned j;
    longint      x0, y0, x1, y1, top;
    parity = 1'b0;
    for (int unsigned i = 0; i < poly_n; i++) begin
      j   = (i + 1 == poly_n) ? 0 : i + 1;
      x0  = poly_x[i];
      y0  = poly_y[i];
      x1  = poly_x[j];
      y1  = poly_y[j];
      top = (y0 > y1) ? y0 : y1;
      if ((y0 > py && y1 > py) || (y0 < py && y1 < py) || y0 == y1 || top == py) continue;
      if (crosses_right(x0, y0, x1, y1, px, py)) parity = ~parity;
    end
    return parity;
  endfunction

  task automatic apply_command(cmd_beat_t b);
    verdict_t v;
    case (b.cmd)
      CMD_START: begin
        poly_x[0]  = b.x;
        poly_y[0]  = b.y;
        poly_n     = 1;
        hit_tally  = '0;
        test_tally = '0;
        n_vertex_beats++;
      end
      CMD_APPEND: begin
        if (poly_n < MaxVertices) begin
          poly_x[poly_n] = b.x;
          poly_y[poly_n] = b.y;
          poly_n++;
        end
        n_vertex_beats++;
      end
      default: begin
        v.pt_in = point_in_poly(b.x, b.y);
        if (test_tally != '1) test_tally++;
        if (v.pt_in && hit_tally != '1) hit_tally++;
        if (b.cmd == CMD_LAST) begin
          v.poly_in  = ({hit_tally, 1'b0} >= {1'b0, test_tally});
          v.last     = 1'b1;
          hit_tally  = '0;
          test_tally = '0;
        end else begin
          v.poly_in = 1'b0;
          v.last    = 1'b0;
        end
        verdict_q = {verdict_q, v};
        n_test_beats++;
      end
    endcase
    if (poly_n > largest_poly) largest_poly = poly_n;
  endtask

  task automatic flag_error(string msg);
    n_errors++;
    if (n_errors <= ReportMax) $display("tb: mismatch %0d: %s", n_errors, msg);
  endtask

  task automatic add_beat(cmd_e c, logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y);
    cmd_beat_t b;
    b.cmd = c;
    b.x   = x;
    b.y   = y;
    pending_q = {pending_q, b};
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord(int scale);
    case (scale)
      ScaleNear: return $urandom_range(0, 128) - 64;
      ScaleMid:  return $urandom_range(0, 2 ** 21) - 2 ** 20;
      default:   return $urandom;
    endcase
  endfunction

  task automatic gen_directed();
    add_beat(CMD_TEST, 0, 0);
    add_beat(CMD_LAST, CMax, CMin);
    add_beat(CMD_START, 0, 0);
    add_beat(CMD_TEST, -5, 0);
    add_beat(CMD_APPEND, 10, 10);
    add_beat(CMD_TEST, 5, 5);
    add_beat(CMD_TEST, -1, 3);
    add_beat(CMD_START, CMin, CMin);
    add_beat(CMD_APPEND, CMax, CMin);
    add_beat(CMD_APPEND, CMax, CMax);
    add_beat(CMD_APPEND, CMin, CMax);
    add_beat(CMD_TEST, 0, 0);
    add_beat(CMD_TEST, CMin, 0);
    add_beat(CMD_TEST, CMax, 0);
    add_beat(CMD_TEST, 0, CMin);
    add_beat(CMD_TEST, 0, CMax);
    add_beat(CMD_LAST, CMin, CMax - 1);
    add_beat(CMD_START, -1000, -1000);
    add_beat(CMD_APPEND, 1000, -999);
    add_beat(CMD_APPEND, 3, 2000);
    add_beat(CMD_TEST, 2, 1999);
    add_beat(CMD_TEST, 999, -999);
    add_beat(CMD_TEST, -1000, -1000);
    add_beat(CMD_LAST, 500, 500);
    // long reference polygon
    add_beat(CMD_START, rand_coord(ScaleNear), rand_coord(ScaleNear));
    for (int i = 1; i < LongPoly; i++)
      add_beat(CMD_APPEND, rand_coord(ScaleNear), rand_coord(ScaleNear));
    add_beat(CMD_TEST, 0, 0);
    add_beat(CMD_TEST, rand_coord(ScaleNear), rand_coord(ScaleNear));
    add_beat(CMD_LAST, rand_coord(ScaleNear), rand_coord(ScaleNear));
  endtask

  task automatic gen_random();
    int                       n_gen, scale, nv, nt, mode, pick;
    logic signed [CoordW-1:0] vx[10];
    logic signed [CoordW-1:0] vy[10];
    logic signed [CoordW-1:0] tx, ty;
    n_gen = 0;
    while (n_gen < RandomBeats) begin
      if ($urandom_range(0, 99) < 85) begin
        pick  = $urandom_range(0, 99);
        scale = (pick < 70) ? ScaleNear : (pick < 90) ? ScaleMid : ScaleFull;
        nv    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        for (int i = 0; i < nv; i++) begin
          vx[i] = rand_coord(scale);
          vy[i] = rand_coord(scale);
          add_beat((i == 0) ? CMD_START : CMD_APPEND, vx[i], vy[i]);
        end
        nt = $urandom_range(1, 8);
        for (int t = 0; t < nt; t++) begin
          mode = $urandom_range(0, 3);
          tx   = (mode == 1) ? vx[$urandom_range(0, nv - 1)] : rand_coord(scale);
          ty   = (mode <= 1) ? vy[$urandom_range(0, nv - 1)] : rand_coord(scale);
          add_beat((t == nt - 1) ? CMD_LAST : CMD_TEST, tx, ty);
        end
        n_gen += nv + nt;
      end else begin
        nt = $urandom_range(1, 4);
        for (int t = 0; t < nt; t++) begin
          scale = ($urandom_range(0, 1) == 0) ? ScaleNear : ScaleFull;
          add_beat(cmd_e'($urandom_range(0, 3)), rand_coord(scale), rand_coord(scale));
        end
        n_gen += nt;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    poly_n         = 0;
    hit_tally      = '0;
    test_tally     = '0;
    n_cmd_beats    = 0;
    n_vertex_beats = 0;
    n_test_beats   = 0;
    n_verdicts     = 0;
    largest_poly   = 0;
    n_errors       = 0;
    for (int i = 0; i < MaxVertices; i++) begin
      poly_x[i] = '0;
      poly_y[i] = '0;
    end
    gen_directed();
    gen_random();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_q.size() != 0 || verdict_q.size() != 0) @(posedge clk_i);
    repeat (MaxVertices + 16) @(posedge clk_i);
    $display("tb: %0d command beats (%0d vertex, %0d test), %0d verdicts checked",
             n_cmd_beats, n_vertex_beats, n_test_beats, n_verdicts);
    $display("tb: largest reference polygon %0d vertices, %0d mismatches",
             largest_poly, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // predict on input beats, then check output beats, in one process
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_beat <= pt_if.valid && pt_if.ready;
      if (pt_if.valid && pt_if.ready) begin
        apply_command(pending_q.pop_front());
        n_cmd_beats++;
      end
      if (res_if.valid && res_if.ready) begin
        n_verdicts++;
        got = '{res_if.point_inside, res_if.polygon_inside, res_if.last};
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected result beat %b/%b/%b",
                               got.pt_in, got.poly_in, got.last));
        end else begin
          want = verdict_q.pop_front();
          if (got.pt_in !== want.pt_in || got.poly_in !== want.poly_in ||
              got.last !== want.last)
            flag_error($sformatf("verdict %0d: want point %b poly %b last %b, got %b %b %b",
                                 n_verdicts, want.pt_in, want.poly_in, want.last,
                                 got.pt_in, got.poly_in, got.last));
        end
      end
      if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("tb: timeout after %0d quiet cycles, %0d verdicts pending",
                 quiet_cycles, verdict_q.size());
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // command driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pt_if.valid   <= 1'b0;
      pt_if.cmd     <= CMD_START;
      pt_if.point_x <= '0;
      pt_if.point_y <= '0;
    end else if (!pt_if.valid || in_beat) begin
      if (pending_q.size() != 0 &&
          ((n_cmd_beats >= 300 && n_cmd_beats < 420) || $urandom_range(0, 99) >= IdlePct)) begin
        pt_if.valid   <= 1'b1;
        pt_if.cmd     <= pending_q[0].cmd;
        pt_if.point_x <= pending_q[0].x;
        pt_if.point_y <= pending_q[0].y;
      end else begin
        pt_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && n_verdicts >= HoldAfter) begin
      hold_done    <= 1'b1;
      hold_left    <= HoldCycles;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= (n_verdicts >= 150 && n_verdicts < 230) ||
                      ($urandom_range(0, 99) >= IdlePct);
    end
  end

endmodule

[polygon_inside_polygon_test_unit.f]
+incdir+rtl
rtl/pipt_pkg.sv
rtl/pipt_if.sv
rtl/pipt_ram.sv
rtl/pipt_edge.sv
rtl/pipt_ctrl.sv
rtl/polygon_inside_polygon_test_unit.sv
verif/tb_polygon_inside_polygon_test_unit.sv
